// File: src/pcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer package
// Request and response payload types, result kinds and parser phase codes.
// ----------------------------------------------------------------------------
package pcd_pkg;

   // Number of bytes in the length, type and CRC fields of a chunk.
   localparam int unsigned HDR_BYTES = 4;

   // Width of the decoded payload length and of the byte counter.
   localparam int unsigned LEN_W = 31;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_LEN  = 4'b0001,
      PH_TYPE = 4'b0010,
      PH_DATA = 4'b0100,
      PH_CRC  = 4'b1000
   } phase_type;

   // One input byte of the chunk stream.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       chunk_start;
   } req_type;

   // One result item.
   typedef struct packed {
      kind_type          kind;
      logic [7:0]        byte_out;
      logic [LEN_W-1:0]  chunk_length;
      logic [31:0]       chunk_code;
      logic              crc_ok;
   } rsp_type;

   // Request held in the input register.
   typedef struct packed {
      logic    valid;
      req_type data;
   } item_type;

   // Result offered by the parser for the held request.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// File: src/pcd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer input register
// Holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module pcd_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcd_pkg::req_type req_data,
   input  logic             advance,
   output pcd_pkg::item_type item
);
   import pcd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // A held request that the parser cannot consume blocks the port.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   // Valid flag of the held request.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads whenever a request is accepted.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

// File: src/pcd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer parser
// Chunk phase tracking, field capture and running CRC-32 over type and
// payload bytes; forms the result for the held request.
// ----------------------------------------------------------------------------
module pcd_parser (
   input  logic                clock,
   input  logic                reset,
   input  pcd_pkg::item_type   item,
   input  logic                advance,
   output pcd_pkg::result_type result
);
   import pcd_pkg::*;

   localparam logic [31:0]      CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0]      CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [LEN_W-1:0] HDR_COUNT = LEN_W'(HDR_BYTES);

   // Reflected CRC-32 update for one byte, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [31:0]      length_ff, length_in;
   logic [31:0]      type_ff, type_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      stored_ff, stored_in;

   phase_type        phase_v;
   logic [LEN_W-1:0] count_v;
   logic [LEN_W-1:0] count_inc;
   logic [7:0]       b;

   assign b         = item.data.byte_in;
   assign phase_v   = item.data.chunk_start ? PH_LEN : phase_ff;
   assign count_v   = item.data.chunk_start ? '0 : count_ff;
   assign count_inc = count_v + LEN_W'(1);

   // Next state and result for the held byte.
   always_comb begin
      phase_in  = phase_v;
      count_in  = count_inc;
      length_in = length_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      stored_in = stored_ff;
      result.valid             = 1'b0;
      result.data.kind         = KIND_PAYLOAD;
      result.data.byte_out     = 8'd0;
      result.data.chunk_length = length_ff[LEN_W-1:0];
      result.data.chunk_code   = type_ff;
      result.data.crc_ok       = 1'b0;
      case (phase_v)
         PH_LEN: begin
            // The first length byte clears the fields of the previous chunk.
            if (count_v == '0) begin
               length_in = {24'd0, b};
               type_in   = '0;
               stored_in = '0;
               crc_in    = CRC_INIT;
            end else begin
               length_in = {length_ff[23:0], b};
            end
            if (count_inc >= HDR_COUNT) begin
               phase_in = PH_TYPE;
               count_in = '0;
            end
         end
         PH_TYPE: begin
            type_in = {type_ff[23:0], b};
            crc_in  = crc_byte(crc_ff, b);
            if (count_inc >= HDR_COUNT) begin
               count_in = '0;
               // An empty payload goes straight to the CRC field.
               phase_in = (length_ff[LEN_W-1:0] == '0) ? PH_CRC : PH_DATA;
               result.valid           = 1'b1;
               result.data.kind       = KIND_HEADER;
               result.data.chunk_code = type_in;
            end
         end
         PH_DATA: begin
            crc_in = crc_byte(crc_ff, b);
            if (count_inc >= length_ff[LEN_W-1:0]) begin
               count_in = '0;
               phase_in = PH_CRC;
            end
            result.valid         = 1'b1;
            result.data.byte_out = b;
         end
         PH_CRC: begin
            stored_in = {stored_ff[23:0], b};
            if (count_inc >= HDR_COUNT) begin
               phase_in = PH_LEN;
               count_in = '0;
               result.valid       = 1'b1;
               result.data.kind   = KIND_END;
               result.data.crc_ok = ((crc_ff ^ CRC_INIT) == stored_in);
            end
         end
         default: begin
            phase_in = PH_LEN;
            count_in = '0;
         end
      endcase
   end

   // Parser state commits only when the held byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         count_ff  <= '0;
         length_ff <= '0;
         type_ff   <= '0;
         crc_ff    <= CRC_INIT;
         stored_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         type_ff   <= type_in;
         crc_ff    <= crc_in;
         stored_ff <= stored_in;
      end
   end

   // Field phases never count past the field size.
   a_field_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> (count_ff < HDR_COUNT))
      else $error("field byte counter out of range");

   // The payload phase only runs while bytes remain.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (count_ff < length_ff[LEN_W-1:0]))
      else $error("payload counter reached the chunk length");

   // Only a chunk end carries a CRC verdict; only payload carries a byte.
   a_result_fields: assert property (@(posedge clock) disable iff (reset)
      (item.valid && result.valid && (result.data.kind != KIND_END)) |->
      !result.data.crc_ok && ((result.data.kind == KIND_PAYLOAD) ||
      (result.data.byte_out == 8'd0)))
      else $error("result fields inconsistent with kind");

endmodule

// File: src/png_chunk_deframer_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer with CRC-32 check
// Parses length, type, payload and CRC fields of a chunk byte stream, passes
// payload bytes through and reports the header and the CRC verdict.
//
//   Channel  Ports                          Direction  Moves
//   req      req_valid req_stall req_data   in         one stream byte
//   rsp      rsp_valid rsp_stall rsp_data   out        one result
//
// One byte is accepted per cycle unless the request port stalls; its result
// reaches the response port through the input register, then the result register.
// The CRC-32 byte update is combinational XOR logic in the parser.
// Reset is synchronous and brings the parser to the length field.
// A stalled response holds; a new request is still taken while the held
// byte produces no result or the response register can be refilled.
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc32 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcd_pkg::rsp_type rsp_data
);
   import pcd_pkg::*;

   item_type   item;
   result_type result;
   logic       advance;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   // The held byte moves on unless its result finds the output occupied.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = item.valid && (out_free || !result.valid);

   pcd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .item      (item)
   );

   pcd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   // Result register.
   assign rsp_valid_in = (advance && result.valid) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A consumed byte with a result shows up as a response next cycle.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (advance && result.valid) |=> rsp_valid)
      else $error("consumed result not presented");

   // A stalled response is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(advance && result.valid))
      else $error("stalled response overwritten");

   // The request port only stalls while a byte is held.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item.valid)
      else $error("request stalled with no byte held");

endmodule

// File: tb/png_chunk_deframer_crc32_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer testbench
// Feeds chunk byte streams (well-formed chunks with good and bad CRCs, cut-off
// chunks, restarts and stray bytes) through the request channel. A local copy
// of the parser predicts every result, and each accepted response is checked
// field by field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc32_test;
   import pcd_pkg::*;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_LIMIT = 2000;

   localparam logic [31:0] TYPE_IHDR = "IHDR";
   localparam logic [31:0] TYPE_PLTE = "PLTE";
   localparam logic [31:0] TYPE_IDAT = "IDAT";
   localparam logic [31:0] TYPE_IEND = "IEND";
   localparam logic [31:0] TYPE_TEXT = "tEXt";

   typedef logic [7:0] byte_list_type[$];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Parser state as the testbench tracks it.
   phase_type        ps_phase = PH_LEN;
   logic [LEN_W-1:0] ps_count = '0;
   logic [31:0]      ps_length = '0;
   logic [31:0]      ps_type = '0;
   logic [31:0]      ps_crc = '1;
   logic [31:0]      ps_stored = '0;

   rsp_type deframer_results_due[$];
   int      mismatch_count = 0;
   int      bytes_sent = 0;
   int      burst_left = 0;
   bit      sender_idles = 1'b0;
   bit      receiver_idles = 1'b0;
   int      hold_ticket = 0;

   png_chunk_deframer_crc32 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Reflected CRC-32 update for one byte.
   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] n;
      n = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         n = n[0] ? ((n >> 1) ^ CRC_POLY) : (n >> 1);
      end
      return n;
   endfunction

   // Advances the tracked parser by one stream byte; returns 1 when the byte
   // causes a result, which is then left in r.
   function automatic bit parse_stream_byte(input logic [7:0] b, input logic s,
                                            output rsp_type r);
      bit produced;
      produced = 1'b0;
      r = '0;
      if (s) begin
         ps_phase = PH_LEN;
         ps_count = '0;
      end
      case (ps_phase)
         PH_LEN: begin
            // The first length byte clears everything from the last chunk.
            if (ps_count == 0) begin
               ps_length = '0;
               ps_type = '0;
               ps_stored = '0;
               ps_crc = '1;
            end
            ps_length = {ps_length[23:0], b};
            ps_count = ps_count + 1'b1;
            if (ps_count >= HDR_BYTES) begin
               ps_phase = PH_TYPE;
               ps_count = '0;
            end
         end
         PH_TYPE: begin
            ps_type = {ps_type[23:0], b};
            ps_crc = crc_step(ps_crc, b);
            ps_count = ps_count + 1'b1;
            if (ps_count >= HDR_BYTES) begin
               ps_count = '0;
               if (ps_length[LEN_W-1:0] == 0) begin
                  ps_phase = PH_CRC;
               end else begin
                  ps_phase = PH_DATA;
               end
               r.kind = KIND_HEADER;
               produced = 1'b1;
            end
         end
         PH_DATA: begin
            ps_crc = crc_step(ps_crc, b);
            ps_count = ps_count + 1'b1;
            if (ps_count >= ps_length[LEN_W-1:0]) begin
               ps_count = '0;
               ps_phase = PH_CRC;
            end
            r.kind = KIND_PAYLOAD;
            r.byte_out = b;
            produced = 1'b1;
         end
         default: begin
            ps_stored = {ps_stored[23:0], b};
            ps_count = ps_count + 1'b1;
            if (ps_count >= HDR_BYTES) begin
               r.kind = KIND_END;
               r.crc_ok = (~ps_crc == ps_stored);
               ps_phase = PH_LEN;
               ps_count = '0;
               produced = 1'b1;
            end
         end
      endcase
      if (produced) begin
         r.chunk_length = ps_length[LEN_W-1:0];
         r.chunk_code = ps_type;
      end
      return produced;
   endfunction

   // Sends one stream byte as a request and records the result it causes.
   task automatic send_byte(input logic [7:0] b, input logic s);
      rsp_type r;
      int gap;
      // Bursts of random length separated by random gaps.
      if (sender_idles && burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_data <= '{byte_in: b, chunk_start: s};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (parse_stream_byte(b, s, r)) deframer_results_due.push_back(r);
      bytes_sent++;
   endtask

   // Lowers valid and waits until every predicted result has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (deframer_results_due.size() != 0);
   endtask

   function automatic byte_list_type random_payload(input int n);
      byte_list_type data;
      for (int i = 0; i < n; i++) data.push_back(8'($urandom_range(0, 255)));
      return data;
   endfunction

   function automatic logic [31:0] random_type();
      case ($urandom_range(0, 5))
         0: return TYPE_IHDR;
         1: return TYPE_PLTE;
         2: return TYPE_IDAT;
         3: return TYPE_IEND;
         4: return TYPE_TEXT;
         default: return $urandom;
      endcase
   endfunction

   // Builds one chunk and sends it; cut_at > 0 stops after that many bytes.
   task automatic send_chunk(input logic [31:0] length_field, input logic [31:0] type_code,
                             input byte_list_type payload, input bit corrupt,
                             input bit start_flag, input int cut_at);
      byte_list_type stream;
      logic [31:0] crc;
      logic [7:0] b;
      int n;
      crc = '1;
      for (int i = 3; i >= 0; i--) stream.push_back(length_field[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) begin
         b = type_code[i*8 +: 8];
         crc = crc_step(crc, b);
         stream.push_back(b);
      end
      foreach (payload[i]) begin
         crc = crc_step(crc, payload[i]);
         stream.push_back(payload[i]);
      end
      crc = ~crc;
      if (corrupt) crc ^= 32'd1 << $urandom_range(0, 31);
      for (int i = 3; i >= 0; i--) stream.push_back(crc[i*8 +: 8]);
      n = (cut_at > 0 && cut_at < stream.size()) ? cut_at : stream.size();
      for (int i = 0; i < n; i++) send_byte(stream[i], start_flag && i == 0);
   endtask

   // A chunk cut off after its first length bytes, abandoned by the next test.
   task automatic test_restart();
      send_chunk(32'd5, TYPE_IDAT, random_payload(5), 1'b0, 1'b1, 3);
   endtask

   // Restart into a chunk whose length field has the top bit set and whose
   // payload holds both extreme byte values; its CRC is wrong.
   task automatic test_length_top_bit();
      byte_list_type data;
      data = {8'h00, 8'hFF};
      send_chunk(32'h8000_0002, TYPE_IDAT, data, 1'b1, 1'b1, 0);
   endtask

   // An empty chunk right after the verdict, without a start mark.
   task automatic test_back_to_back();
      byte_list_type data;
      send_chunk(32'd0, TYPE_IEND, data, 1'b0, 1'b0, 0);
   endtask

   // The receiver holds off for a long stretch while a long payload streams in.
   task automatic test_output_hold();
      hold_ticket++;
      send_chunk(32'd40, TYPE_IDAT, random_payload(40), 1'b0, 1'b1, 0);
      wait_drained();
   endtask

   // The sender pauses until all results are out, then continues the stream.
   task automatic test_pause_until_drained();
      send_chunk(32'd6, TYPE_TEXT, random_payload(6), 1'b0, 1'b1, 0);
      wait_drained();
      send_chunk(32'd3, TYPE_PLTE, random_payload(3), 1'b1, 1'b0, 0);
   endtask

   // Mostly well-formed chunks with random content, some cut-off chunks with
   // random length fields, and some stray bytes.
   task automatic test_random_chunks(input int n_bytes, input bit sender_gaps,
                                     input bit receiver_gaps);
      int stop_at;
      int pick;
      int len;
      bit need_start;
      byte_list_type data;
      sender_idles = sender_gaps;
      receiver_idles = receiver_gaps;
      stop_at = bytes_sent + n_bytes;
      need_start = 1'b1;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            need_start = 1'b1;
         end else if (pick == 1) begin
            data = random_payload($urandom_range(0, 6));
            send_chunk($urandom, random_type(), data, 1'b0, 1'b1,
                       $urandom_range(1, 8 + data.size()));
            need_start = 1'b1;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                              : $urandom_range(0, 12);
            data = random_payload(len);
            send_chunk({($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0, 31'(len)}, random_type(),
                       data, $urandom_range(0, 3) == 0,
                       need_start || $urandom_range(0, 1) == 1, 0);
            need_start = 1'b0;
            if ($urandom_range(0, 24) == 0) wait_drained();
         end
      end
   endtask

   task automatic flag_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // Response checker: each accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (deframer_results_due.size() == 0) begin
            flag_field("unexpected result", 64'd0, 64'(rsp_data.kind));
         end else begin
            want = deframer_results_due.pop_front();
            if (rsp_data.kind !== want.kind) begin
               flag_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            end
            if (rsp_data.byte_out !== want.byte_out) begin
               flag_field("byte_out", 64'(want.byte_out), 64'(rsp_data.byte_out));
            end
            if (rsp_data.chunk_length !== want.chunk_length) begin
               flag_field("chunk_length", 64'(want.chunk_length),
                          64'(rsp_data.chunk_length));
            end
            if (rsp_data.chunk_code !== want.chunk_code) begin
               flag_field("chunk_code", 64'(want.chunk_code), 64'(rsp_data.chunk_code));
            end
            if (rsp_data.crc_ok !== want.crc_ok) begin
               flag_field("crc_ok", 64'(want.crc_ok), 64'(rsp_data.crc_ok));
            end
         end
      end
   end

   // Receiver stall: a long hold when one is requested, otherwise a shifting
   // random pattern that is sometimes all clear.
   int          hold_served = 0;
   int          hold_left = 0;
   logic [31:0] stall_bits = '0;
   int          stall_bits_left = 0;

   always @(posedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_bits_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_bits = '0;
               1: stall_bits = $urandom & $urandom;
               default: stall_bits = $urandom;
            endcase
            if (!receiver_idles) stall_bits = '0;
            stall_bits_left = 32;
         end
         rsp_stall <= stall_bits[0];
         stall_bits = stall_bits >> 1;
         stall_bits_left--;
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_restart();
      test_length_top_bit();
      test_back_to_back();
      test_output_hold();
      test_pause_until_drained();
      test_random_chunks(350, 1'b1, 1'b1);
      test_random_chunks(350, 1'b1, 1'b0);
      test_random_chunks(350, 1'b0, 1'b1);

      // Let the last results out, then wait on for strays before the verdict.
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && deframer_results_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/pcd_pkg.sv
src/pcd_in_reg.sv
src/pcd_parser.sv
src/png_chunk_deframer_crc32.sv
tb/png_chunk_deframer_crc32_test.sv
